FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent assertions with and without reset masking.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every rising clock edge, masked while rst is high
`define SAT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check prop at every rising clock edge, reset included
`define SAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/sat_pkg.sv
// ----------------------------------------------------------------------------
// Sorted array table package
// Sizes, codes and shared types of the sorted value table.
// ----------------------------------------------------------------------------
package sat_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam int OP_W     = 2;
   localparam int VAL_W    = 32;
   localparam int POS_W    = 6;
   localparam int ST_W     = 2;
   localparam int INDEX_W  = 6;
   localparam int COUNT_W  = 7;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
   localparam logic [ST_W-1:0] ST_BAD       = 2'd3;

   typedef logic [IDX_W-1:0]        addr_type;
   typedef logic [CNT_W-1:0]        cnt_type;
   typedef logic signed [VAL_W-1:0] val_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_type;

endpackage

FILE: sv/sorted_array_table_core.sv
// ----------------------------------------------------------------------------
// Sorted array table core
// Keeps signed 32-bit values in ascending order and runs insert, search and
// delete as entry-by-entry walks over a single-port-read table RAM.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with rsp_valid, and it cannot be held off.
// Insert walks down from the top entry, one entry per cycle, and search
// walks up from entry 0; delete moves the later entries down one per
// cycle. The walk rate is one RAM read per cycle through the shared
// compare unit. A full-table insert, an empty-table insert or search, a
// rejected delete, a delete of the last entry and an unused operation
// code answer in the cycle after the transfer and leave busy low.
// There is no clearing pass after reset: only written entries are read.
// ----------------------------------------------------------------------------
module sorted_array_table_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [sat_pkg::OP_W-1:0]        req_operation,
   input  logic signed [sat_pkg::VAL_W-1:0] req_value,
   input  logic [sat_pkg::POS_W-1:0]       req_position,
   output logic                            rsp_valid,
   output logic [sat_pkg::ST_W-1:0]        rsp_status,
   output logic [sat_pkg::INDEX_W-1:0]     rsp_index,
   output logic [sat_pkg::COUNT_W-1:0]     rsp_count
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_WALK,
      S_INS_PLACE,
      S_SEARCH,
      S_DEL_WALK
   } state_type;

   state_type                  state_ff, state_in;
   sat_pkg::addr_type          ptr_ff, ptr_in;
   sat_pkg::cnt_type           count_ff, count_in;
   sat_pkg::val_type           value_ff, value_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [sat_pkg::ST_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [sat_pkg::INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [sat_pkg::COUNT_W-1:0] rsp_count_ff;

   logic                       ram_we;
   sat_pkg::addr_type          ram_waddr;
   sat_pkg::val_type           ram_wdata;
   sat_pkg::addr_type          ram_raddr;
   sat_pkg::val_type           ram_rdata;
   sat_pkg::cmp_type           cmp;
   sat_pkg::cnt_type           pos_ext;
   sat_pkg::addr_type          ptr_up;
   sat_pkg::addr_type          ptr_dn;

   sat_ram #(
      .DATA_W (sat_pkg::VAL_W),
      .DEPTH  (sat_pkg::CAPACITY)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   sat_cmp u_cmp (
      .key    (value_ff),
      .entry  (ram_rdata),
      .result (cmp)
   );

   assign pos_ext = sat_pkg::CNT_W'(req_position);
   assign ptr_up  = ptr_ff + sat_pkg::IDX_W'(1);
   assign ptr_dn  = ptr_ff - sat_pkg::IDX_W'(1);

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      count_in      = count_ff;
      value_in      = value_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      ram_we        = 1'b0;
      ram_waddr     = ptr_ff;
      ram_wdata     = value_ff;
      ram_raddr     = ptr_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               value_in     = req_value;
               rsp_valid_in = 1'b1;
               rsp_index_in = '0;
               case (req_operation)
                  sat_pkg::OP_INSERT: begin
                     if (count_ff == sat_pkg::CNT_W'(sat_pkg::CAPACITY)) begin
                        rsp_status_in = sat_pkg::ST_FULL;
                     end else if (count_ff == '0) begin
                        ram_we        = 1'b1;
                        ram_waddr     = '0;
                        ram_wdata     = req_value;
                        count_in      = sat_pkg::CNT_W'(1);
                        rsp_status_in = sat_pkg::ST_OK;
                     end else begin
                        rsp_valid_in = 1'b0;
                        ram_raddr    = sat_pkg::IDX_W'(count_ff - sat_pkg::CNT_W'(1));
                        ptr_in       = sat_pkg::IDX_W'(count_ff - sat_pkg::CNT_W'(1));
                        state_in     = S_INS_WALK;
                     end
                  end
                  sat_pkg::OP_SEARCH: begin
                     if (count_ff == '0) begin
                        rsp_status_in = sat_pkg::ST_NOT_FOUND;
                     end else begin
                        rsp_valid_in = 1'b0;
                        ram_raddr    = '0;
                        ptr_in       = '0;
                        state_in     = S_SEARCH;
                     end
                  end
                  sat_pkg::OP_DELETE: begin
                     if (pos_ext >= count_ff) begin
                        rsp_status_in = sat_pkg::ST_BAD;
                     end else if (pos_ext + sat_pkg::CNT_W'(1) == count_ff) begin
                        count_in      = count_ff - sat_pkg::CNT_W'(1);
                        rsp_status_in = sat_pkg::ST_OK;
                     end else begin
                        rsp_valid_in = 1'b0;
                        ram_raddr    = sat_pkg::IDX_W'(pos_ext + sat_pkg::CNT_W'(1));
                        ptr_in       = sat_pkg::IDX_W'(pos_ext + sat_pkg::CNT_W'(1));
                        state_in     = S_DEL_WALK;
                     end
                  end
                  default: begin
                     rsp_status_in = sat_pkg::ST_BAD;
                  end
               endcase
            end
         end
         S_INS_WALK: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_up;
            if (cmp.lt) begin
               ram_wdata = ram_rdata;
               if (ptr_ff == '0) begin
                  state_in = S_INS_PLACE;
               end else begin
                  ram_raddr = ptr_dn;
                  ptr_in    = ptr_dn;
               end
            end else begin
               ram_wdata     = value_ff;
               count_in      = count_ff + sat_pkg::CNT_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = sat_pkg::ST_OK;
               rsp_index_in  = sat_pkg::INDEX_W'(ptr_up);
               state_in      = S_IDLE;
            end
         end
         S_INS_PLACE: begin
            ram_we        = 1'b1;
            ram_waddr     = '0;
            ram_wdata     = value_ff;
            count_in      = count_ff + sat_pkg::CNT_W'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = sat_pkg::ST_OK;
            rsp_index_in  = '0;
            state_in      = S_IDLE;
         end
         S_SEARCH: begin
            if (cmp.eq) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = sat_pkg::ST_OK;
               rsp_index_in  = sat_pkg::INDEX_W'(ptr_ff);
               state_in      = S_IDLE;
            end else if (sat_pkg::CNT_W'(ptr_ff) + sat_pkg::CNT_W'(1) == count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = sat_pkg::ST_NOT_FOUND;
               rsp_index_in  = '0;
               state_in      = S_IDLE;
            end else begin
               ram_raddr = ptr_up;
               ptr_in    = ptr_up;
            end
         end
         S_DEL_WALK: begin
            ram_we    = 1'b1;
            ram_waddr = ptr_dn;
            ram_wdata = ram_rdata;
            if (sat_pkg::CNT_W'(ptr_ff) + sat_pkg::CNT_W'(1) == count_ff) begin
               count_in      = count_ff - sat_pkg::CNT_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = sat_pkg::ST_OK;
               rsp_index_in  = '0;
               state_in      = S_IDLE;
            end else begin
               ram_raddr = ptr_up;
               ptr_in    = ptr_up;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= sat_pkg::COUNT_W'(count_in);
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

FILE: sv/sat_ram.sv
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sat_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_W-1:0]        wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

FILE: sv/sat_cmp.sv
// ----------------------------------------------------------------------------
// Signed compare unit
// Shared less-than and equal compare of the key against one entry.
// ----------------------------------------------------------------------------
module sat_cmp (
   input  sat_pkg::val_type key,
   input  sat_pkg::val_type entry,
   output sat_pkg::cmp_type result
);

   assign result.lt = (key < entry);
   assign result.eq = (key == entry);

endmodule

FILE: sv/sat_chk.sv
// ----------------------------------------------------------------------------
// Sorted array table checker
// Port-level checks of the command and result behavior, bound to the core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sat_chk (
   input logic                         clock,
   input logic                         reset,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic [sat_pkg::ST_W-1:0]     rsp_status,
   input logic [sat_pkg::INDEX_W-1:0]  rsp_index,
   input logic [sat_pkg::COUNT_W-1:0]  rsp_count
);

   logic err_rsp;
   logic full_rsp;
   logic full_count;

   assign full_rsp   = rsp_valid && (rsp_status == sat_pkg::ST_FULL);
   assign err_rsp    = rsp_valid && (rsp_status == sat_pkg::ST_FULL ||
                                     rsp_status == sat_pkg::ST_BAD);
   assign full_count = (rsp_count == sat_pkg::COUNT_W'(sat_pkg::CAPACITY));

   `SAT_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!busy && !rsp_valid), "not idle after reset")
   `SAT_ASSERT(a_done_result, clock, reset, $fell(busy) |-> rsp_valid, "walk ended without result")
   `SAT_ASSERT(a_err_index, clock, reset, err_rsp |-> (rsp_index == '0), "error with nonzero index")
   `SAT_ASSERT(a_full_count, clock, reset, full_rsp |-> full_count, "full status below capacity")
   `SAT_ASSERT(a_busy_result, clock, reset, $rose(busy) |-> !rsp_valid, "result at walk start")

endmodule

bind sorted_array_table_core sat_chk u_sat_chk (.*);
